// ----- src/flf16_pkg.sv -----
package flf16_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hFE;
  localparam logic [7:0] SYNC_SECOND = 8'hFB;
  localparam logic [8:0] FLETCH_MOD  = 9'd255;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_LEN   = 3'd2,
    PH_PAY   = 3'd3,
    PH_CHK0  = 3'd4,
    PH_CHK1  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_REJECT   = 3'd1,
    ST_GOOD     = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_ZEROLEN  = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic       frame_end;
    logic       is_payload;
    logic [7:0] payload_byte;
  } result_t;

  // One operand stays below 255 and neither exceeds 255, so one conditional subtract is enough.
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FLETCH_MOD) begin
      s = s - FLETCH_MOD;
    end
    return s[7:0];
  endfunction

endpackage

// ----- src/sync_length_frame_fletcher16_checker_top.sv -----
// Framed byte-stream checker: hunts for the sync pair FE FB, takes a length byte,
// passes that many payload bytes (tuser high) while accumulating a Fletcher-16,
// then checks two check bytes sent high first. Every input beat gives exactly one
// output beat; tlast marks the second check byte, which carries the verdict in
// the status field (0 accepted, 1 rejected while hunting, 2 good, 3 mismatch,
// 4 zero length). One byte is taken every clock while the skid entry is empty;
// each result is registered in the output register, or in the skid entry if the
// output is stalled. A two-entry output stage (register plus skid) still takes
// the byte offered during a downstream stall; input then pauses until the skid
// entry drains. Hunting resumes on the byte right after a frame ends.
module sync_length_frame_fletcher16_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
  output logic        m_tuser,   // is_payload
  output logic        m_tlast    // frame_end
);

  logic               accept;
  flf16_pkg::result_t step_result;
  flf16_pkg::result_t out_result;

  assign accept = s_tvalid & s_tready;

  flf16_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .data_in (s_tdata),
    .result  (step_result)
  );

  flf16_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {5'd0, out_result.status, out_result.payload_byte};
  assign m_tuser = out_result.is_payload;
  assign m_tlast = out_result.frame_end;

endmodule

// ----- src/flf16_core.sv -----
module flf16_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_in,
  output flf16_pkg::result_t  result
);

  flf16_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] sum_low, sum_low_next;
  logic [7:0] sum_high, sum_high_next;
  logic [7:0] check_high, check_high_next;
  logic       length_was_zero, length_was_zero_next;
  logic [7:0] pay_low;
  logic [7:0] pay_left;

  assign pay_low  = flf16_pkg::add_mod255(sum_low, data_in);
  assign pay_left = bytes_left - 8'd1;

  // next state
  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    sum_low_next         = sum_low;
    sum_high_next        = sum_high;
    check_high_next      = check_high;
    length_was_zero_next = length_was_zero;
    unique case (phase)
      flf16_pkg::PH_HUNT1: begin
        phase_next = (data_in == flf16_pkg::SYNC_SECOND) ? flf16_pkg::PH_LEN
                                                         : flf16_pkg::PH_HUNT0;
      end
      flf16_pkg::PH_LEN: begin
        bytes_left_next      = data_in;
        sum_low_next         = 8'd0;
        sum_high_next        = 8'd0;
        length_was_zero_next = (data_in == 8'd0);
        phase_next = (data_in == 8'd0) ? flf16_pkg::PH_CHK0 : flf16_pkg::PH_PAY;
      end
      flf16_pkg::PH_PAY: begin
        sum_low_next    = pay_low;
        sum_high_next   = flf16_pkg::add_mod255(sum_high, pay_low);
        bytes_left_next = pay_left;
        if (pay_left == 8'd0) begin
          phase_next = flf16_pkg::PH_CHK0;
        end
      end
      flf16_pkg::PH_CHK0: begin
        check_high_next = data_in;
        phase_next      = flf16_pkg::PH_CHK1;
      end
      flf16_pkg::PH_CHK1: begin
        phase_next = flf16_pkg::PH_HUNT0;
      end
      default: begin
        // first sync hunt, also recovers from unused codes
        phase_next = (data_in == flf16_pkg::SYNC_FIRST) ? flf16_pkg::PH_HUNT1
                                                        : flf16_pkg::PH_HUNT0;
      end
    endcase
  end

  // outputs
  always_comb begin
    result.payload_byte = 8'd0;
    result.is_payload   = 1'b0;
    result.frame_end    = 1'b0;
    result.status       = flf16_pkg::ST_ACCEPT;
    unique case (phase)
      flf16_pkg::PH_HUNT1: begin
        if (data_in != flf16_pkg::SYNC_SECOND) begin
          result.status = flf16_pkg::ST_REJECT;
        end
      end
      flf16_pkg::PH_LEN, flf16_pkg::PH_CHK0: begin
        result.status = flf16_pkg::ST_ACCEPT;
      end
      flf16_pkg::PH_PAY: begin
        result.payload_byte = data_in;
        result.is_payload   = 1'b1;
      end
      flf16_pkg::PH_CHK1: begin
        result.frame_end = 1'b1;
        if (length_was_zero) begin
          result.status = flf16_pkg::ST_ZEROLEN;
        end else if (check_high == sum_high && data_in == sum_low) begin
          result.status = flf16_pkg::ST_GOOD;
        end else begin
          result.status = flf16_pkg::ST_MISMATCH;
        end
      end
      default: begin
        if (data_in != flf16_pkg::SYNC_FIRST) begin
          result.status = flf16_pkg::ST_REJECT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= flf16_pkg::PH_HUNT0;
      bytes_left      <= 8'd0;
      sum_low         <= 8'd0;
      sum_high        <= 8'd0;
      check_high      <= 8'd0;
      length_was_zero <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      sum_low         <= sum_low_next;
      sum_high        <= sum_high_next;
      check_high      <= check_high_next;
      length_was_zero <= length_was_zero_next;
    end
  end

endmodule

// ----- src/flf16_skid.sv -----
module flf16_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  flf16_pkg::result_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output flf16_pkg::result_t out_data
);

  logic               skid_valid;
  flf16_pkg::result_t skid_data;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (out_valid && out_ready) begin
        // beat taken: refill from the skid stage first
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_valid;
        end
      end else if (!out_valid) begin
        out_valid <= in_valid;
      end else if (in_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (out_valid && out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (!out_valid) begin
      out_data <= in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule
